>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/ldmd_pkg.sv
// ----------------------------------------------------------------------------
// ldmd_pkg
// Constants and types shared by the length-delimited message deframer.
// ----------------------------------------------------------------------------
package ldmd_pkg;

  // Width of the gathered length; valid range 8..56
  localparam int unsigned LENGTH_BITS   = 32;
  // Most varint bytes a length may take
  localparam int unsigned MAX_LEN_BYTES = (LENGTH_BITS + 6) / 7;
  // Varint byte counter width
  localparam int unsigned CNT_W         = 3;

  localparam logic [7:0] KEY_RESET = 8'h0A;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // One result from the parser, valid marks that a byte caused one
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] payload;
    logic       last;
  } result_t;

endpackage

>>> hdl/ldmd_in_if.sv
// ----------------------------------------------------------------------------
// ldmd_in_if
// Byte stream channel into the deframer: valid/ready plus one byte.
// ----------------------------------------------------------------------------
interface ldmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

>>> hdl/ldmd_out_if.sv
// ----------------------------------------------------------------------------
// ldmd_out_if
// Result channel out of the deframer: valid/ready plus kind, payload, last.
// ----------------------------------------------------------------------------
interface ldmd_out_if;
  logic           valid;
  logic           ready;
  ldmd_pkg::kind_e kind;
  logic [7:0]     payload;
  logic           last;

  modport source (output valid, output kind, output payload, output last, input ready);
  modport sink   (input valid, input kind, input payload, input last, output ready);
endinterface

>>> hdl/ldmd_parser.sv
// ----------------------------------------------------------------------------
// ldmd_parser
// Framing state machine: key check, varint length gather, payload count.
// Updates its state on each accepted word and gives the result combinationally.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ldmd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i,
  output ldmd_pkg::result_t   res_o
);

  localparam int unsigned LB    = ldmd_pkg::LENGTH_BITS;
  localparam int unsigned WIDEW = ldmd_pkg::LENGTH_BITS + 7;
  localparam int unsigned CW    = ldmd_pkg::CNT_W;

  typedef enum logic [1:0] {
    PH_KEY  = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [LB-1:0]   remaining_q, remaining_d;
  logic [CW-1:0]   count_q, count_d;
  logic [7:0]      key_q;

  logic [5:0]       shamt;
  logic [WIDEW-1:0] wide;
  logic             overflow;
  logic             more;
  logic             too_many;
  logic [LB-1:0]    merged;
  logic [LB-1:0]    rem_dec;
  ldmd_pkg::result_t res;

  // Place the 7 length bits at 7 * count; high part flags an oversize length
  assign shamt    = 6'(count_q) * 6'd7;
  assign wide     = WIDEW'(byte_i[6:0]) << shamt;
  assign overflow = |wide[WIDEW-1:LB];
  assign more     = byte_i[7];
  assign too_many = ({1'b0, count_q} + (CW+1)'(1)) >= (CW+1)'(ldmd_pkg::MAX_LEN_BYTES);
  assign merged   = remaining_q | wide[LB-1:0];
  assign rem_dec  = remaining_q - LB'(remaining_q != '0);

  // Next state and result for the word at the input
  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    count_d     = count_q;
    res.valid   = 1'b0;
    res.kind    = ldmd_pkg::KIND_DATA;
    res.payload = 8'h00;
    res.last    = 1'b0;
    case (phase_q)
      PH_LEN: begin
        if (overflow || (more && too_many)) begin
          phase_d     = PH_KEY;
          remaining_d = '0;
          count_d     = '0;
          res.valid   = 1'b1;
          res.kind    = ldmd_pkg::KIND_ERROR;
        end else if (more) begin
          remaining_d = merged;
          count_d     = count_q + CW'(1);
        end else begin
          remaining_d = merged;
          count_d     = '0;
          if (merged == '0) begin
            phase_d   = PH_KEY;
            res.valid = 1'b1;
            res.kind  = ldmd_pkg::KIND_EMPTY;
            res.last  = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        remaining_d = rem_dec;
        if (rem_dec == '0) phase_d = PH_KEY;
        res.valid   = 1'b1;
        res.kind    = ldmd_pkg::KIND_DATA;
        res.payload = byte_i;
        res.last    = (remaining_q <= LB'(1));
      end
      default: begin
        // key phase, also the unused code
        phase_d = PH_KEY;
        if (byte_i != key_q) begin
          res.valid = 1'b1;
          res.kind  = ldmd_pkg::KIND_ERROR;
        end else begin
          phase_d     = PH_LEN;
          remaining_d = '0;
          count_d     = '0;
        end
      end
    endcase
  end

  assign res_o = res;

  // State and key register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_KEY;
      remaining_q <= '0;
      count_q     <= '0;
      key_q       <= ldmd_pkg::KEY_RESET;
    end else begin
      if (step_i) begin
        phase_q     <= phase_d;
        remaining_q <= remaining_d;
        count_q     <= count_d;
      end
      if (cfg_we_i) key_q <= cfg_data_i;
    end
  end

  // Payload phase always has bytes still due
  `ASSERT_IMPL(a_data_nonzero, clk_i, rst_ni, phase_q == PH_DATA, remaining_q != '0)
  // Varint counter never passes the byte limit
  `ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1,
               (CW+1)'(count_q) < (CW+1)'(ldmd_pkg::MAX_LEN_BYTES))
  // An accepted error always drops back to waiting for a key
  `ASSERT_NEXT(a_err_to_key, clk_i, rst_ni,
               step_i && res.valid && res.kind == ldmd_pkg::KIND_ERROR,
               phase_q == PH_KEY && count_q == '0)

endmodule

>>> hdl/length_delimited_message_deframer_unit.sv
// ----------------------------------------------------------------------------
// length_delimited_message_deframer_unit
// Splits a byte stream of key / varint length / payload messages.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one stream byte per word. out_ch carries one result word:
//   kind (payload byte, empty message or framing error), the payload byte
//   and a last mark on the final byte of a message or an empty message.
//   Key and length bytes produce no word except on error or zero length.
//   cfg_we_i / cfg_data_i write the expected key byte (0x0A after reset);
//   write it only while the block is idle.
// Timing:
//   One byte is accepted per cycle unless stalled. A result appears on
//   out_ch in the cycle after its byte, from a single output register;
//   the parser state updates in the same cycle: no bubble between bytes.
// Reset:
//   rst_ni clears the parser to waiting for a key and empties the output.
// Stall:
//   While a result waits on a low out_ch.ready, in_ch.ready drops; when the
//   receiver takes the result, a new byte is accepted in that same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module length_delimited_message_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ldmd_in_if.sink     in_ch,
  ldmd_out_if.source  out_ch,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i
);

  ldmd_pkg::result_t res;
  logic              accept;
  logic              out_valid_q;
  ldmd_pkg::kind_e   kind_q;
  logic [7:0]        payload_q;
  logic              last_q;

  // Free to take a word when the output is empty or being drained
  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  ldmd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .byte_i     (in_ch.stream_byte),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= res.valid;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res.valid) begin
      kind_q    <= res.kind;
      payload_q <= res.payload;
      last_q    <= res.last;
    end
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.kind    = kind_q;
  assign out_ch.payload = payload_q;
  assign out_ch.last    = last_q;

  // A word that yields a result shows it in the next cycle
  `ASSERT_NEXT(a_res_shown, clk_i, rst_ni, accept && res.valid,
               out_valid_q && kind_q == $past(res.kind))

endmodule

>>> sim/deframer_checker.sv
// ----------------------------------------------------------------------------
// deframer_checker
// Watches both channels of the deframer and predicts every result word from
// the accepted stream bytes and key writes. Each accepted result word is
// compared field by field with the oldest prediction; failures are counted.
// ----------------------------------------------------------------------------
module deframer_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  ldmd_in_if         in_ch,
  ldmd_out_if        out_ch,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  output int         fail_count,
  output int         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    AWAIT_KEY  = 2'd0,
    READ_LEN   = 2'd1,
    IN_PAYLOAD = 2'd2
  } parse_phase_e;

  typedef struct {
    ldmd_pkg::kind_e kind;
    logic [7:0]      payload;
    logic            last;
  } frame_word_t;

  // Shadow parser state
  logic [7:0]                       shadow_key;
  parse_phase_e                     shadow_phase;
  logic [ldmd_pkg::LENGTH_BITS-1:0] bytes_due;
  logic [ldmd_pkg::CNT_W-1:0]       len_bytes;

  frame_word_t            due_words[$];

  // Advance the shadow parser by one stream byte; returns 1 if a word results
  function automatic bit parse_byte(input logic [7:0] b, output frame_word_t w);
    int unsigned shift;
    int unsigned room;
    logic [6:0]  bits;
    logic        more;
    logic [63:0] wide;
    w = '{ldmd_pkg::KIND_DATA, 8'h00, 1'b0};
    parse_byte = 1'b0;
    case (shadow_phase)
      READ_LEN: begin
        shift = 7 * int'(len_bytes);
        bits  = b[6:0];
        more  = b[7];
        room  = (shift >= ldmd_pkg::LENGTH_BITS) ? 0 : ldmd_pkg::LENGTH_BITS - shift;
        // too wide a length, or one varint byte too many
        if ((room < 7 && (32'(bits) >> room) != 0) ||
            (more && int'(len_bytes) + 1 >= ldmd_pkg::MAX_LEN_BYTES)) begin
          shadow_phase = AWAIT_KEY;
          bytes_due    = '0;
          len_bytes    = '0;
          w = '{ldmd_pkg::KIND_ERROR, 8'h00, 1'b0};
          return 1'b1;
        end
        wide = 64'(bits) << shift;
        bytes_due = bytes_due | wide[ldmd_pkg::LENGTH_BITS-1:0];
        if (more) begin
          len_bytes = len_bytes + 1'b1;
          return 1'b0;
        end
        len_bytes = '0;
        if (bytes_due == '0) begin
          shadow_phase = AWAIT_KEY;
          w = '{ldmd_pkg::KIND_EMPTY, 8'h00, 1'b1};
          return 1'b1;
        end
        shadow_phase = IN_PAYLOAD;
      end
      IN_PAYLOAD: begin
        w = '{ldmd_pkg::KIND_DATA, b, (bytes_due <= 1)};
        if (bytes_due != '0) bytes_due = bytes_due - 1'b1;
        if (bytes_due == '0) shadow_phase = AWAIT_KEY;
        parse_byte = 1'b1;
      end
      default: begin
        // key phase, also the unused phase code
        shadow_phase = AWAIT_KEY;
        if (b != shadow_key) begin
          w = '{ldmd_pkg::KIND_ERROR, 8'h00, 1'b0};
          return 1'b1;
        end
        shadow_phase = READ_LEN;
        bytes_due    = '0;
        len_bytes    = '0;
      end
    endcase
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  always @(posedge clk_i) begin : watch
    frame_word_t want;
    frame_word_t got;
    if (!rst_ni) begin
      shadow_key   = ldmd_pkg::KEY_RESET;
      shadow_phase = AWAIT_KEY;
      bytes_due    = '0;
      len_bytes    = '0;
      due_words.delete();
    end else begin
      // result word taken by the receiver
      if (out_ch.valid && out_ch.ready) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word kind=%0d payload=%02h last=%0b", $time,
                   out_ch.kind, out_ch.payload, out_ch.last);
          fail_count++;
        end else begin
          want = due_words.pop_front();
          if (out_ch.kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_ch.kind);
            fail_count++;
          end
          if (out_ch.payload !== want.payload) begin
            $display("%0t: payload expected %02h actual %02h", $time,
                     want.payload, out_ch.payload);
            fail_count++;
          end
          if (out_ch.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, out_ch.last);
            fail_count++;
          end
        end
      end
      // stream word accepted by the block
      if (in_ch.valid && in_ch.ready) begin
        if (parse_byte(in_ch.stream_byte, got)) due_words.insert(due_words.size(), got);
      end
      if (cfg_we_i) shadow_key = cfg_data_i;
    end
    pending_count = due_words.size();
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Regression for the length-delimited message deframer. Drives framed byte
// streams (directed corner cases, then random messages, stray bytes and
// broken varint lengths) under several expected keys, with bursty input and
// a stalling receiver; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned BYTES_PER_PHASE = 150;
  localparam int unsigned MAX_LEN_BYTES = ldmd_pkg::MAX_LEN_BYTES;
  // room left for the last varint byte before the length overflows
  localparam int unsigned LAST_ROOM = ldmd_pkg::LENGTH_BITS - 7 * (MAX_LEN_BYTES - 1);

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BURSTY
  } rx_mode_e;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_data_i;
  int         fail_count;
  int         pending_count;
  int unsigned cycles = 0;

  logic [7:0] stream_q[$];

  ldmd_in_if  in_ch();
  ldmd_out_if out_ch();

  length_delimited_message_deframer_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  deframer_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("length_delimited_message_deframer_unit regression: fail");
      $finish;
    end
  end

  // Receiver stalls, in a random mode that is redrawn when its run ends
  initial begin : rx_stall
    rx_mode_e mode;
    int       left;
    out_ch.ready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(5, 60);
      end
      left--;
      case (mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   out_ch.ready <= (left % 8 == 0);
      endcase
    end
  end

  // Append one byte to the stream
  task automatic put_byte(input logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endtask

  // Varint length, optionally padded with zero groups up to pad_to bytes
  task automatic push_length(input int unsigned len, input int unsigned pad_to);
    int unsigned v;
    int unsigned nb;
    logic        more;
    logic [7:0]  b;
    v  = len;
    nb = 0;
    do begin
      b = 8'(v & 32'h7F);
      v = v >> 7;
      nb++;
      more = (v != 0) || (nb < pad_to);
      put_byte(more ? (b | 8'h80) : b);
    end while (more);
  endtask

  // Key then a length whose last varint byte overflows LENGTH_BITS
  task automatic push_too_wide(input logic [7:0] key);
    put_byte(key);
    repeat (MAX_LEN_BYTES - 1) put_byte(8'h80 | 8'($urandom_range(0, 127)));
    put_byte({1'($urandom_range(0, 1)), 7'($urandom_range(1 << LAST_ROOM, 127))});
  endtask

  // Key then one varint byte too many, all with the continuation bit
  task automatic push_too_long(input logic [7:0] key);
    put_byte(key);
    repeat (MAX_LEN_BYTES) put_byte(8'h80 | 8'($urandom_range(0, 127)));
  endtask

  task automatic push_message(input logic [7:0] key, input int unsigned len,
                              input int unsigned pad_to);
    put_byte(key);
    push_length(len, pad_to);
    repeat (len) put_byte(8'($urandom));
  endtask

  task automatic load_directed(input logic [7:0] key);
    push_message(key, 0, 1);
    put_byte(key);                     // one byte, value zero
    put_byte(8'h01);
    put_byte(8'h00);
    put_byte(key);                     //                                     two bytes, both with the top bit set
    put_byte(8'h02);
    put_byte(8'hFF);
    put_byte(8'h80);
    put_byte(~key);                    // wrong key
    if (LAST_ROOM < 7) push_too_wide(key);
    push_too_long(key);
    put_byte(key);                     // padded varint length of one
    put_byte(8'h81);
    put_byte(8'h00);
    put_byte(8'h7F);
  endtask

  // Mostly well-formed messages; the rest stray bytes and broken lengths
  task automatic load_random(input logic [7:0] key, input int unsigned target);
    int unsigned start;
    int unsigned r;
    int unsigned len;
    int unsigned pad_to;
    logic [7:0]  b;
    start = stream_q.size();
    while (stream_q.size() - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        r = $urandom_range(0, 99);
        if (r < 10)      len = 0;
        else if (r < 75) len = $urandom_range(1, 8);
        else if (r < 96) len = $urandom_range(9, 40);
        else             len = $urandom_range(128, 300);
        pad_to = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_LEN_BYTES) : 1;
        push_message(key, len, pad_to);
      end else if (r < 80) begin
        b = 8'($urandom);
        put_byte((b == key) ? ~key : b);
      end else if (r < 90 && LAST_ROOM < 7) begin
        push_too_wide(key);
      end else begin
        push_too_long(key);
      end
    end
  endtask

  // Send the queue in bursts with random gaps; starts and ends on a falling edge
  task automatic send_stream();
    int unsigned burst;
    int unsigned gap;
    while (stream_q.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && stream_q.size() > 0) begin
        in_ch.valid       <= 1'b1;
        in_ch.stream_byte <= stream_q.pop_front();
        @(posedge clk_i);
        while (!in_ch.ready) @(posedge clk_i);
        @(negedge clk_i);
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_key(input logic [7:0] k);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= k;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] key;
    in_ch.valid       = 1'b0;
    in_ch.stream_byte = 8'h00;
    cfg_we_i          = 1'b0;
    cfg_data_i        = 8'h00;
    rst_ni            = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corner cases under the reset key
    key = ldmd_pkg::KEY_RESET;
    load_directed(key);
    send_stream();
    settle();

    // random traffic under several keys, extremes first
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       key = 8'h00;
        1:       key = 8'hFF;
        4:       key = ldmd_pkg::KEY_RESET;
        default: key = 8'($urandom);
      endcase
      write_key(key);
      load_random(key, BYTES_PER_PHASE);
      send_stream();
      settle();
    end

    if (fail_count == 0) begin
      $display("length_delimited_message_deframer_unit regression: pass");
    end else begin
      $display("length_delimited_message_deframer_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ldmd_pkg.sv
hdl/ldmd_in_if.sv
hdl/ldmd_out_if.sv
hdl/ldmd_parser.sv
hdl/length_delimited_message_deframer_unit.sv
sim/deframer_checker.sv
sim/testbench.sv
